// ===== hw/rtl/planar_pid_differential_thrust_core_macros.svh =====
// ----------------------------------------------------------------------------
// planar_pid_differential_thrust_core_macros.svh
// Assertion macros shared by the thrust core.
// ----------------------------------------------------------------------------
`ifndef PLANAR_PID_DIFFERENTIAL_THRUST_CORE_MACROS_SVH
`define PLANAR_PID_DIFFERENTIAL_THRUST_CORE_MACROS_SVH

// Implication checked on every clock edge out of reset
`define PPDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true out of reset
`define PPDT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ppdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdt_pkg
// Constants shared by the planar PID thrust core and its units.
// ----------------------------------------------------------------------------
package ppdt_pkg;

  // Shared datapath width of the serial multiplier and divider
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned DIV_W      = 16;
  localparam int unsigned CNT_W      = 7;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_BAND = 2'd3;

  // Result fields
  localparam int unsigned THRUST_W   = 11;
  localparam int unsigned PUMP_W     = 2;
  localparam logic [PUMP_W-1:0] PUMP_OFF = 2'd0;
  localparam logic [PUMP_W-1:0] PUMP_IN  = 2'd1;
  localparam logic [PUMP_W-1:0] PUMP_OUT = 2'd2;

  // Fixed point: PID terms in 1/4096 us
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned PID_W      = 23;
  localparam int unsigned MIX_W      = 25;
  localparam logic signed [PID_W-1:0] PID_LIMIT  = 23'sd2048000;
  localparam logic signed [MIX_W-1:0] THRUST_MID = 25'sd6144000;
  localparam logic signed [MIX_W-1:0] THRUST_MIN = 25'sd4096000;
  localparam logic signed [MIX_W-1:0] THRUST_MAX = 25'sd8192000;
  localparam logic [DIV_W-1:0] MS_PER_S    = 16'd1000;
  localparam logic [DIV_W-1:0] FALLBACK_MS = 16'd10;

  // Integrator
  localparam int unsigned INTEG_W = 48;

endpackage

// ===== hw/rtl/ppdt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdt_if
// Valid/ready channels for control ticks and thrust results.
// ----------------------------------------------------------------------------
interface ppdt_in_if #(
  parameter int unsigned POSITION_BITS = 24
);
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] target_x;
  logic signed [POSITION_BITS-1:0] target_y;
  logic signed [POSITION_BITS-1:0] target_z;
  logic signed [POSITION_BITS-1:0] position_x;
  logic signed [POSITION_BITS-1:0] position_y;
  logic signed [POSITION_BITS-1:0] position_z;
  logic [15:0]                     step_time;
  logic                            clear_history;

  modport source (output valid, target_x, target_y, target_z, position_x, position_y,
                  position_z, step_time, clear_history, input ready);
  modport sink   (input valid, target_x, target_y, target_z, position_x, position_y,
                  position_z, step_time, clear_history, output ready);
endinterface

interface ppdt_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] left_thrust;
  logic [10:0] right_thrust;
  logic [1:0]  pump_command;

  modport source (output valid, left_thrust, right_thrust, pump_command, input ready);
  modport sink   (input valid, left_thrust, right_thrust, pump_command, output ready);
endinterface

// ===== hw/rtl/ppdt_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdt_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ppdt_mul #(
  parameter int unsigned MB = 26
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppdt_pkg::DATA_W-1:0] a_i,
  input  logic [MB-1:0]             b_i,
  output logic                      done_o,
  output logic [ppdt_pkg::DATA_W-1:0] prod_o
);
  import ppdt_pkg::*;

  logic              busy_q;
  logic [DATA_W-1:0] acc_q, a_q;
  logic [MB-1:0]     b_q;

  // Finished once no set multiplier bits remain
  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= {a_q[DATA_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MB-1:1]};
    end
  end

endmodule

// ===== hw/rtl/ppdt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppdt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppdt_pkg::DATA_W-1:0] num_i,
  input  logic [ppdt_pkg::DIV_W-1:0]  den_i,
  output logic                        done_o,
  output logic [ppdt_pkg::DATA_W-1:0] quo_o
);
  import ppdt_pkg::*;

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] num_q;
  logic [DIV_W-1:0]  rem_q, den_q;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = num_q;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, num_q[DATA_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DATA_W);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Quotient bits fill the dividend register from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= fits ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
      num_q <= {num_q[DATA_W-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/planar_pid_differential_thrust_core.sv =====
`timescale 1ns / 1ps
// Sequencing: both axes share the serial multiplier and the restoring divider; one tick
//   is processed at a time, and the next tick is taken while a result waits.
// Reset: asynchronous, active low; gains and dead band take their reset values,
//   PID history is cleared.
// ----------------------------------------------------------------------------
// planar_pid_differential_thrust_core
// Two-axis PID with differential thrust mixing and a depth dead band.
// ----------------------------------------------------------------------------
module planar_pid_differential_thrust_core #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ppdt_in_if.sink                         in_ch,
  ppdt_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [ppdt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppdt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ppdt_pkg::*;
  `include "planar_pid_differential_thrust_core_macros.svh"

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned MB = POSITION_BITS + 2;
  // Integrator sum width: holds the 48-bit state plus the widest err * dt step
  localparam int unsigned SUM_W = ((PB + DIV_W + 1 > INTEG_W) ? PB + DIV_W + 1 : INTEG_W) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_GO   = 4'd2;
  localparam logic [3:0] S_MINT = 4'd3;
  localparam logic [3:0] S_MP   = 4'd4;
  localparam logic [3:0] S_MI   = 4'd5;
  localparam logic [3:0] S_DI   = 4'd6;
  localparam logic [3:0] S_MK   = 4'd7;
  localparam logic [3:0] S_MD   = 4'd8;
  localparam logic [3:0] S_DD   = 4'd9;
  localparam logic [3:0] S_MIX  = 4'd10;

  logic [3:0] state_q;
  logic       axis_q;

  // Configuration registers
  logic [CFG_DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q, band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= 16'd256;
      gain_i_q <= '0;
      gain_d_q <= '0;
      band_q   <= 16'd160;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_P:     gain_p_q <= cfg_data_i;
        CFG_GAIN_I:     gain_i_q <= cfg_data_i;
        CFG_GAIN_D:     gain_d_q <= cfg_data_i;
        CFG_DEPTH_BAND: band_q   <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Latched tick
  logic signed [PB-1:0] tx_q, ty_q, tz_q, px_q, py_q, pz_q;
  logic [DIV_W-1:0]     dt_q;

  // Per-axis history and working values
  logic signed [INTEG_W-1:0] integ_q [2];
  logic signed [PB:0]        prev_q [2];
  logic signed [PB:0]        err_q;
  logic signed [PB+1:0]      de_q;
  logic signed [DATA_W-1:0]  acc_q;
  logic signed [PID_W-1:0]   pid_q [2];

  // Output register
  logic                out_valid_q;
  logic [THRUST_W-1:0] left_q, right_q;
  logic [PUMP_W-1:0]   pump_q;

  logic in_fire;
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Error of the current axis
  logic signed [PB:0] err_d;
  assign err_d = axis_q ? (PB+1)'(ty_q) - (PB+1)'(py_q) : (PB+1)'(tx_q) - (PB+1)'(px_q);

  logic [PB:0]          err_mag;
  logic [PB+1:0]        de_mag;
  logic [INTEG_W-1:0]   integ_mag;
  logic signed [INTEG_W-1:0] integ_cur;
  assign integ_cur = integ_q[axis_q];
  assign err_mag   = err_q[PB] ? (PB+1)'(-err_q) : err_q;
  assign de_mag    = de_q[PB+1] ? (PB+2)'(-de_q) : de_q;
  assign integ_mag = integ_cur[INTEG_W-1] ? INTEG_W'(-integ_cur) : integ_cur;

  // Shared serial units
  logic              mul_start, mul_done, div_start, div_done;
  logic [DATA_W-1:0] mul_a, mul_prod, div_num, div_quo;
  logic [MB-1:0]     mul_b;
  logic [DIV_W-1:0]  div_den;

  ppdt_mul #(.MB(MB)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  ppdt_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Operand selection for each step of the sequence
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = mul_prod;
    div_den   = dt_q;
    case (state_q)
      S_GO: begin
        mul_start = 1'b1;
        mul_a     = DATA_W'(err_mag);
        mul_b     = MB'(dt_q);
      end
      S_MINT: begin
        mul_start = mul_done;
        mul_a     = DATA_W'(err_mag);
        mul_b     = MB'(gain_p_q);
      end
      S_MP: begin
        mul_start = mul_done;
        mul_a     = DATA_W'(integ_mag);
        mul_b     = MB'(gain_i_q);
      end
      S_MI: begin
        div_start = mul_done;
        div_den   = MS_PER_S;
      end
      S_DI: begin
        mul_start = div_done;
        mul_a     = DATA_W'(gain_d_q);
        mul_b     = MB'(MS_PER_S);
      end
      S_MK: begin
        mul_start = mul_done;
        mul_a     = mul_prod;
        mul_b     = de_mag;
      end
      S_MD: begin
        div_start = mul_done;
      end
      default: ;
    endcase
  end

  // Integrator update with 48-bit saturation
  logic signed [SUM_W-1:0]   int_step, int_sum;
  logic signed [INTEG_W-1:0] int_sat;
  assign int_step = err_q[PB] ? -$signed({1'b0, mul_prod[SUM_W-2:0]})
                              :  $signed({1'b0, mul_prod[SUM_W-2:0]});
  assign int_sum  = SUM_W'(integ_cur) + int_step;
  always_comb begin
    if (int_sum[SUM_W-1:INTEG_W-1] != {(SUM_W-INTEG_W+1){int_sum[SUM_W-1]}}) begin
      int_sat = int_sum[SUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      int_sat = int_sum[INTEG_W-1:0];
    end
  end

  // Signed quotient terms and the clamped axis output
  logic signed [DATA_W-1:0] i_term, d_term, pid_sum;
  logic signed [PID_W-1:0]  pid_clamped;
  assign i_term  = integ_cur[INTEG_W-1] ? -$signed(div_quo) : $signed(div_quo);
  assign d_term  = de_q[PB+1] ? -$signed(div_quo) : $signed(div_quo);
  assign pid_sum = acc_q + d_term;
  always_comb begin
    if (pid_sum > DATA_W'(PID_LIMIT)) begin
      pid_clamped = PID_LIMIT;
    end else if (pid_sum < -DATA_W'(PID_LIMIT)) begin
      pid_clamped = -PID_LIMIT;
    end else begin
      pid_clamped = pid_sum[PID_W-1:0];
    end
  end

  // Mixing and depth dead band
  logic signed [MIX_W-1:0] left_raw, right_raw, left_c, right_c;
  logic signed [PB:0]      dz;
  logic signed [PB+1:0]    band_s;
  logic [PUMP_W-1:0]       pump_d;
  assign left_raw  = THRUST_MID + MIX_W'(pid_q[0]) + MIX_W'(pid_q[1]);
  assign right_raw = THRUST_MID + MIX_W'(pid_q[0]) - MIX_W'(pid_q[1]);
  assign left_c    = (left_raw < THRUST_MIN) ? THRUST_MIN :
                     (left_raw > THRUST_MAX) ? THRUST_MAX : left_raw;
  assign right_c   = (right_raw < THRUST_MIN) ? THRUST_MIN :
                     (right_raw > THRUST_MAX) ? THRUST_MAX : right_raw;
  assign dz        = (PB+1)'(tz_q) - (PB+1)'(pz_q);
  assign band_s    = $signed((PB+2)'(band_q));
  always_comb begin
    if ((PB+2)'(dz) > band_s) begin
      pump_d = PUMP_IN;
    end else if ((PB+2)'(dz) < -band_s) begin
      pump_d = PUMP_OUT;
    end else begin
      pump_d = PUMP_OFF;
    end
  end

  logic mix_fire;
  assign mix_fire = (state_q == S_MIX) && (!out_valid_q || out_ch.ready);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_q     <= 1'b0;
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      prev_q[0]  <= '0;
      prev_q[1]  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            axis_q  <= 1'b0;
            state_q <= S_LOAD;
            if (in_ch.clear_history) begin
              integ_q[0] <= '0;
              integ_q[1] <= '0;
              prev_q[0]  <= '0;
              prev_q[1]  <= '0;
            end
          end
        end
        S_LOAD: state_q <= S_GO;
        S_GO:   state_q <= S_MINT;
        S_MINT: if (mul_done) begin
          integ_q[axis_q] <= int_sat;
          state_q         <= S_MP;
        end
        S_MP:   if (mul_done) state_q <= S_MI;
        S_MI:   if (mul_done) state_q <= S_DI;
        S_DI:   if (div_done) state_q <= S_MK;
        S_MK:   if (mul_done) state_q <= S_MD;
        S_MD:   if (mul_done) state_q <= S_DD;
        S_DD: if (div_done) begin
          prev_q[axis_q] <= err_q;
          axis_q         <= 1'b1;
          state_q        <= axis_q ? S_MIX : S_LOAD;
        end
        S_MIX:  if (mix_fire) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tx_q <= in_ch.target_x;
      ty_q <= in_ch.target_y;
      tz_q <= in_ch.target_z;
      px_q <= in_ch.position_x;
      py_q <= in_ch.position_y;
      pz_q <= in_ch.position_z;
      dt_q <= (in_ch.step_time == '0) ? FALLBACK_MS : in_ch.step_time;
    end
    if (state_q == S_LOAD) begin
      err_q <= err_d;
      de_q  <= (PB+2)'(err_d) - (PB+2)'(prev_q[axis_q]);
    end
    if ((state_q == S_MP) && mul_done) begin
      acc_q <= err_q[PB] ? -$signed(mul_prod) : $signed(mul_prod);
    end
    if ((state_q == S_DI) && div_done) begin
      acc_q <= acc_q + i_term;
    end
    if ((state_q == S_DD) && div_done) begin
      pid_q[axis_q] <= pid_clamped;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mix_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_fire) begin
      left_q  <= left_c[FRAC_BITS+THRUST_W-1:FRAC_BITS];
      right_q <= right_c[FRAC_BITS+THRUST_W-1:FRAC_BITS];
      pump_q  <= pump_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.left_thrust  = left_q;
  assign out_ch.right_thrust = right_q;
  assign out_ch.pump_command = pump_q;

  // Checks
  `PPDT_ASSERT(a_left_range, out_valid_q |-> (left_q >= 11'd1000 && left_q <= 11'd2000), "left thrust out of range")
  `PPDT_ASSERT(a_right_range, out_valid_q |-> (right_q >= 11'd1000 && right_q <= 11'd2000), "right thrust out of range")
  `PPDT_NEVER(a_pump_code, out_valid_q && pump_q > PUMP_OUT, "invalid pump code")
  `PPDT_ASSERT(a_new_result, $rose(out_valid_q) |-> $past(state_q) == S_MIX, "result without mixing step")

endmodule

// ===== dv/tb_planar_pid_differential_thrust_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_pid_differential_thrust_core
// Self-checking bench for the planar PID thrust core. An in-bench model of
// both PID axes, the thrust mixer and the depth dead band predicts each
// result. Directed ticks hit the extremes and each integrator limit, then random ticks run
// under several gain settings, with random stalls on both channels in all but one of them.
// ----------------------------------------------------------------------------
module tb_planar_pid_differential_thrust_core;
  import ppdt_pkg::*;

  localparam int          POS_W      = 24;
  localparam int          CLK_HALF   = 6;
  localparam longint      CYCLE_MAX  = 6000000;
  localparam longint      INTEG_HI   = (longint'(1) <<< 47) - 1;
  localparam longint      INTEG_LO   = -(longint'(1) <<< 47);
  localparam longint      OUT_LIM    = 500 * 4096;
  localparam longint      MIX_MID    = 1500 * 4096;
  localparam longint      MIX_LO     = 1000 * 4096;
  localparam longint      MIX_HI     = 2000 * 4096;
  localparam int          DRAIN_WAIT = 600;

  typedef struct {
    logic signed [POS_W-1:0] tx, ty, tz, px, py, pz;
    logic [15:0]             dt;
    logic                    clr;
  } tick_t;

  typedef struct {
    logic [THRUST_W-1:0] left;
    logic [THRUST_W-1:0] right;
    logic [PUMP_W-1:0]   pump;
  } thrust_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_GAIN_P;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ppdt_in_if #(.POSITION_BITS(POS_W)) in_ch ();
  ppdt_out_if                          out_ch ();

  planar_pid_differential_thrust_core #(.POSITION_BITS(POS_W)) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Model copy of registers and PID history
  longint unsigned kp, ki, kd, band;
  longint          integ_x, integ_y, prev_x, prev_y;
  thrust_t         thrust_q[$];
  bit              stall_en = 1'b1;
  int              mismatches = 0;
  int              n_ticks = 0;
  int              n_results = 0;
  int              n_sat = 0;
  longint          cycles = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // (factor * x) / div truncated toward zero
  function automatic longint scale_div(longint unsigned factor, longint x,
                                       longint unsigned div);
    longint unsigned mag;
    longint unsigned q;
    mag = (x < 0) ? longint'(-x) : x;
    q   = (factor * mag) / div;
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint pid_step(longint err, longint unsigned dt,
                                      ref longint integ, ref longint prev);
    longint sum;
    sum = integ + err * longint'(dt);
    if (sum > INTEG_HI || sum < INTEG_LO) n_sat++;
    integ = clamp(sum, INTEG_LO, INTEG_HI);
    sum = longint'(kp) * err + scale_div(ki, integ, 1000)
        + scale_div(kd * 1000, err - prev, dt);
    prev = err;
    return clamp(sum, -OUT_LIM, OUT_LIM);
  endfunction

  function automatic thrust_t predict_thrust(tick_t t);
    thrust_t         r;
    longint unsigned dt;
    longint          ox, oy, l, rt, dz;
    dt = (t.dt == 0) ? 64'd10 : 64'(t.dt);
    if (t.clr) begin
      integ_x = 0; integ_y = 0; prev_x = 0; prev_y = 0;
    end
    ox = pid_step(longint'(t.tx) - longint'(t.px), dt, integ_x, prev_x);
    oy = pid_step(longint'(t.ty) - longint'(t.py), dt, integ_y, prev_y);
    l  = clamp(MIX_MID + ox + oy, MIX_LO, MIX_HI);
    rt = clamp(MIX_MID + ox - oy, MIX_LO, MIX_HI);
    dz = longint'(t.tz) - longint'(t.pz);
    r.left  = THRUST_W'(l >>> FRAC_BITS);
    r.right = THRUST_W'(rt >>> FRAC_BITS);
    if (dz > longint'(band)) r.pump = PUMP_IN;
    else if (dz < -longint'(band)) r.pump = PUMP_OUT;
    else r.pump = PUMP_OFF;
    return r;
  endfunction

  // Drive one tick; prediction is made at the accepting edge
  task automatic send_tick(tick_t t);
    @(negedge clk_i);
    if (stall_en && $urandom_range(99) < 31) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
    end
    in_ch.target_x = t.tx; in_ch.target_y = t.ty; in_ch.target_z = t.tz;
    in_ch.position_x = t.px; in_ch.position_y = t.py; in_ch.position_z = t.pz;
    in_ch.step_time = t.dt; in_ch.clear_history = t.clr;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    thrust_q.push_back(predict_thrust(t));
    n_ticks++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (thrust_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_GAIN_P: kp = 64'(val);
      CFG_GAIN_I: ki = 64'(val);
      CFG_GAIN_D: kd = 64'(val);
      default:    band = 64'(val);
    endcase
  endtask

  task automatic set_gains(int p, int i, int d, int b);
    write_reg(CFG_GAIN_P, CFG_DATA_W'(p));
    write_reg(CFG_GAIN_I, CFG_DATA_W'(i));
    write_reg(CFG_GAIN_D, CFG_DATA_W'(d));
    write_reg(CFG_DEPTH_BAND, CFG_DATA_W'(b));
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos(bit wide);
    if (wide) return POS_W'($urandom);
    return POS_W'($urandom_range(4000)) - POS_W'(2000);
  endfunction

  // Mostly realistic ticks near the target, some full-range noise
  function automatic tick_t rand_tick();
    tick_t t;
    bit    wide;
    wide  = ($urandom_range(99) < 20);
    t.tx  = rand_pos(wide);
    t.ty  = rand_pos(wide);
    t.tz  = rand_pos(wide);
    t.px  = wide ? rand_pos(1) : t.tx + rand_pos(0);
    t.py  = wide ? rand_pos(1) : t.ty + rand_pos(0);
    t.pz  = wide ? rand_pos(1) : t.tz + rand_pos(0);
    case ($urandom_range(9))
      0:       t.dt = 16'($urandom);
      1:       t.dt = 16'($urandom_range(2));
      default: t.dt = 16'($urandom_range(5, 30));
    endcase
    t.clr = ($urandom_range(99) < 4);
    return t;
  endfunction

  function automatic tick_t mk(int tx, int ty, int tz, int px, int py, int pz,
                               int dt, bit clr);
    tick_t t;
    t.tx = POS_W'(tx); t.ty = POS_W'(ty); t.tz = POS_W'(tz);
    t.px = POS_W'(px); t.py = POS_W'(py); t.pz = POS_W'(pz);
    t.dt = 16'(dt); t.clr = clr;
    return t;
  endfunction

  // Result checker: sample at the rising edge, move ready at the falling edge
  initial begin
    thrust_t exp_r;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        n_results++;
        if (thrust_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result at %0t", $realtime);
        end else begin
          exp_r = thrust_q.pop_front();
          if (out_ch.left_thrust !== exp_r.left || out_ch.right_thrust !== exp_r.right ||
              out_ch.pump_command !== exp_r.pump) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d exp L=%0d R=%0d pump=%0d got L=%0d R=%0d pump=%0d",
                       n_results, exp_r.left, exp_r.right, exp_r.pump,
                       out_ch.left_thrust, out_ch.right_thrust, out_ch.pump_command);
          end
        end
      end
      @(negedge clk_i);
      out_ch.ready = !(stall_en && $urandom_range(99) < 31);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("planar_pid_differential_thrust_core verification failed");
      $finish;
    end
  end

  task automatic test_extremes();
    set_gains(256, 0, 0, 160);
    send_tick(mk(0, 0, 0, 0, 0, 0, 10, 1'b0));
    send_tick(mk(8388607, -8388608, 8388607, -8388608, 8388607, -8388608, 65535, 1'b0));
    send_tick(mk(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, 1, 1'b1));
    send_tick(mk(100, 50, 161, 0, 0, 0, 0, 1'b0));        // zero step time
    send_tick(mk(-100, 50, -161, 0, 0, 0, 0, 1'b0));
    send_tick(mk(0, 0, 160, 0, 0, 0, 20, 1'b0));           // on the band edge
    send_tick(mk(0, 0, -160, 0, 0, 0, 20, 1'b0));
    send_tick(mk(-1, -1, -1, -1, -1, -1, 65535, 1'b1));
    wait_drained();
    set_gains(65535, 65535, 65535, 0);
    send_tick(mk(1, -1, 1, 0, 0, 0, 1, 1'b1));
    send_tick(mk(-1, 1, -1, 0, 0, 0, 0, 1'b0));
    send_tick(mk(8388607, 8388607, 0, -8388608, -8388608, 0, 1, 1'b0));
    send_tick(mk(-8388608, -8388608, 0, 8388607, 8388607, 0, 65535, 1'b0));
    send_tick(mk(5, 5, 0, 0, 0, 0, 1, 1'b1));
    wait_drained();
    set_gains(0, 0, 0, 65535);
    send_tick(mk(300, -300, 65536, 0, 0, 0, 10, 1'b0));
    send_tick(mk(300, -300, -65536, 0, 0, 0, 10, 1'b0));
    send_tick(mk(0, 0, 65535, 0, 0, 0, 10, 1'b0));
    wait_drained();
  endtask

  // Drive one integrator into each 48-bit limit
  task automatic test_integrator_saturation();
    set_gains(0, 1, 0, 160);
    send_tick(mk(8388607, -8388608, 0, -8388608, 8388607, 0, 65535, 1'b1));
    repeat (140) send_tick(mk(8388607, -8388608, 0, -8388608, 8388607, 0, 65535, 1'b0));
    send_tick(mk(-8388608, 8388607, 0, 8388607, -8388608, 0, 65535, 1'b0));
    wait_drained();
  endtask

  task automatic test_random_phases();
    int p;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_gains(256, 0, 0, 160);
        1: set_gains(0, 0, 0, 0);
        2: set_gains(65535, 65535, 65535, 65535);
        default: set_gains($urandom_range(2048), $urandom_range(512),
                           $urandom_range(256), $urandom_range(400));
      endcase
      stall_en = (p != 3);
      repeat (190) send_tick(rand_tick());
      stall_en = 1'b1;
      wait_drained();
    end
  endtask

  initial begin
    kp = 256; ki = 0; kd = 0; band = 160;
    integ_x = 0; integ_y = 0; prev_x = 0; prev_y = 0;
    in_ch.valid = 1'b0;
    in_ch.target_x = '0; in_ch.target_y = '0; in_ch.target_z = '0;
    in_ch.position_x = '0; in_ch.position_y = '0; in_ch.position_z = '0;
    in_ch.step_time = '0; in_ch.clear_history = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_integrator_saturation();
    test_random_phases();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Ran %0d ticks over directed extremes, integrator limits and 8 gain phases;",
             n_ticks);
    $display("checked %0d results, %0d saturating integrator steps, %0d mismatches.",
             n_results, n_sat, mismatches);
    if (mismatches == 0 && thrust_q.size() == 0) begin
      $display("planar_pid_differential_thrust_core verification clean");
    end else begin
      $display("planar_pid_differential_thrust_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ppdt_pkg.sv
hw/rtl/ppdt_if.sv
hw/rtl/ppdt_mul.sv
hw/rtl/ppdt_div.sv
hw/rtl/planar_pid_differential_thrust_core.sv
dv/tb_planar_pid_differential_thrust_core.sv
